// ----- hdl/lzd_pkg.sv -----
// Shared constants, register codes and types for the LZ77 window decoder.
package lzd_pkg;

    localparam int WINDOW_DEPTH      = 256;
    localparam int MAX_LITERAL_BYTES = 4;
    localparam int PACK_BYTES        = 8;

    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int NLIT_W = $clog2(MAX_LITERAL_BYTES + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LITERAL_BYTES = 1'b1;

    typedef struct packed {
        logic              err;
        logic [7:0]        distance;
        logic [7:0]        len;
        logic [31:0]       lit;
        logic [NLIT_W-1:0] nlit;
    } t_cmd;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  byte_count;
        logic        last;
        logic        error;
    } t_result;

endpackage

// ----- hdl/lzd_front.sv -----
// Token intake: configuration registers, distance check and projected fill tracking.
module lzd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [lzd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lzd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic [7:0]                     i_distance,
    input  logic [7:0]                     i_match_length,
    input  logic [31:0]                    i_literal,
    output lzd_pkg::t_cmd                  o_cmd
);

    localparam int CMP_W = (lzd_pkg::FILL_W > 9 ? lzd_pkg::FILL_W : 9);
    localparam int SUM_W = CMP_W + 1;

    logic [8:0]                 r_window_size;
    logic [2:0]                 r_literal_bytes;
    logic [lzd_pkg::FILL_W-1:0] r_fill;
    logic [lzd_pkg::FILL_W-1:0] n_fill;

    logic [CMP_W-1:0]           win;
    logic [CMP_W-1:0]           held;
    logic [CMP_W-1:0]           fill_ext;
    logic [3:0]                 lb_ext;
    logic [lzd_pkg::NLIT_W-1:0] nlit;
    logic                       bad;
    logic [SUM_W-1:0]           sum;

    always_comb begin
        fill_ext = CMP_W'(r_fill);
        if (CMP_W'(r_window_size) > CMP_W'(lzd_pkg::WINDOW_DEPTH)) begin
            win = CMP_W'(lzd_pkg::WINDOW_DEPTH);
        end else begin
            win = CMP_W'(r_window_size);
        end
        held = (fill_ext < win) ? fill_ext : win;

        lb_ext = {1'b0, r_literal_bytes};
        if (lb_ext == 4'd0) begin
            nlit = lzd_pkg::NLIT_W'(1);
        end else if (lb_ext > 4'(lzd_pkg::MAX_LITERAL_BYTES)) begin
            nlit = lzd_pkg::NLIT_W'(lzd_pkg::MAX_LITERAL_BYTES);
        end else begin
            nlit = lzd_pkg::NLIT_W'(lb_ext);
        end

        bad = (CMP_W'(i_distance) > held) || (i_distance == 8'd0 && i_match_length != 8'd0);

        sum = SUM_W'(r_fill) + SUM_W'(i_match_length) + SUM_W'(nlit);
        if (sum > SUM_W'(lzd_pkg::WINDOW_DEPTH)) begin
            n_fill = lzd_pkg::FILL_W'(lzd_pkg::WINDOW_DEPTH);
        end else begin
            n_fill = sum[lzd_pkg::FILL_W-1:0];
        end

        o_cmd.err      = bad;
        o_cmd.distance = i_distance;
        o_cmd.len      = i_match_length;
        o_cmd.lit      = i_literal;
        o_cmd.nlit     = nlit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size   <= 9'd256;
            r_literal_bytes <= 3'd1;
            r_fill          <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lzd_pkg::REG_WINDOW_SIZE:   r_window_size   <= i_cfg_data[8:0];
                    lzd_pkg::REG_LITERAL_BYTES: r_literal_bytes <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_accept && !bad) begin
                r_fill <= n_fill;
            end
        end
    end

endmodule

// ----- hdl/lzd_cmd_queue.sv -----
// Two-entry command queue between token intake and the copy engine.
module lzd_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lzd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output lzd_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    lzd_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/lzd_back.sv -----
// Copy engine: history window, byte copy and literal append, packing, result register.
module lzd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  lzd_pkg::t_cmd    i_q_cmd,
    output logic             o_q_pop,
    output lzd_pkg::t_result o_res,
    output logic             o_res_valid,
    input  logic             i_res_pop
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_COPY = 3'd2;
    localparam logic [2:0] S_LIT  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam int AW = (lzd_pkg::PTR_W > 8 ? lzd_pkg::PTR_W : 8) + 1;

    logic [7:0]                 r_hist [lzd_pkg::WINDOW_DEPTH];
    logic [7:0]                 r_rdata;

    logic [2:0]                 r_state,     n_state;
    logic [7:0]                 r_dist,      n_dist;
    logic [7:0]                 r_len,       n_len;
    logic [31:0]                r_lit,       n_lit;
    logic [lzd_pkg::NLIT_W-1:0] r_nlit,      n_nlit;
    logic [lzd_pkg::PTR_W-1:0]  r_wp,        n_wp;
    logic [63:0]                r_pack_data, n_pack_data;
    logic [3:0]                 r_pack_cnt,  n_pack_cnt;
    logic                       r_emit_last, n_emit_last;
    logic                       r_emit_err,  n_emit_err;
    logic                       r_out_valid;
    lzd_pkg::t_result           r_out;

    logic                       wr_en;
    logic [7:0]                 wr_byte;
    logic [AW-1:0]              wp_ext;
    logic [AW-1:0]              d_ext;
    logic [AW-1:0]              rd_sum;
    logic [lzd_pkg::PTR_W-1:0]  rd_addr;
    logic [lzd_pkg::PTR_W-1:0]  wp_inc;
    logic                       pack_full;
    logic                       out_free;
    logic                       out_load;

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_res_pop;

    always_comb begin
        wp_ext = AW'(r_wp);
        d_ext  = AW'(r_dist);
        if (wp_ext >= d_ext) begin
            rd_sum = wp_ext - d_ext;
        end else begin
            rd_sum = wp_ext + AW'(lzd_pkg::WINDOW_DEPTH) - d_ext;
        end
        rd_addr = rd_sum[lzd_pkg::PTR_W-1:0];
        if (r_wp == lzd_pkg::PTR_W'(lzd_pkg::WINDOW_DEPTH - 1)) begin
            wp_inc = '0;
        end else begin
            wp_inc = r_wp + 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dist      = r_dist;
        n_len       = r_len;
        n_lit       = r_lit;
        n_nlit      = r_nlit;
        n_wp        = r_wp;
        n_pack_data = r_pack_data;
        n_pack_cnt  = r_pack_cnt;
        n_emit_last = r_emit_last;
        n_emit_err  = r_emit_err;
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;
        wr_byte     = (r_state == S_COPY) ? r_rdata : r_lit[7:0];
        pack_full   = (r_pack_cnt == 4'(lzd_pkg::PACK_BYTES - 1));
        out_load    = 1'b0;

        if (r_state == S_COPY || r_state == S_LIT) begin
            wr_en = 1'b1;
            n_wp  = wp_inc;
            n_pack_data[8*r_pack_cnt[2:0] +: 8] = wr_byte;
            n_pack_cnt = r_pack_cnt + 4'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop     = 1'b1;
                    n_dist      = i_q_cmd.distance;
                    n_len       = i_q_cmd.len;
                    n_lit       = i_q_cmd.lit;
                    n_nlit      = i_q_cmd.nlit;
                    n_pack_data = '0;
                    n_pack_cnt  = '0;
                    n_emit_err  = i_q_cmd.err;
                    n_emit_last = 1'b1;
                    if (i_q_cmd.err) begin
                        n_state = S_EMIT;
                    end else if (i_q_cmd.len != 8'd0) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_LIT;
                    end
                end
            end
            S_READ: begin
                n_state = S_COPY;
            end
            S_COPY: begin
                n_len       = r_len - 8'd1;
                n_emit_last = 1'b0;
                if (pack_full) begin
                    n_state = S_EMIT;
                end else if (r_len != 8'd1) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_LIT;
                end
            end
            S_LIT: begin
                n_lit  = {8'd0, r_lit[31:8]};
                n_nlit = r_nlit - 1'b1;
                if (r_nlit == lzd_pkg::NLIT_W'(1)) begin
                    n_emit_last = 1'b1;
                    n_state     = S_EMIT;
                end else if (pack_full) begin
                    n_emit_last = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_pack_data = '0;
                    n_pack_cnt  = '0;
                    if (r_emit_last) begin
                        n_state = S_IDLE;
                    end else if (r_len != 8'd0) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_LIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[r_wp] <= wr_byte;
        end
        r_rdata <= r_hist[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_dist      <= n_dist;
        r_len       <= n_len;
        r_lit       <= n_lit;
        r_nlit      <= n_nlit;
        r_pack_data <= n_pack_data;
        r_pack_cnt  <= n_pack_cnt;
        r_emit_last <= n_emit_last;
        r_emit_err  <= n_emit_err;
        if (out_load) begin
            r_out.data       <= r_pack_data;
            r_out.byte_count <= r_pack_cnt;
            r_out.last       <= r_emit_last;
            r_out.error      <= r_emit_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/lz77_window_decoder.sv -----
// LZ77 token decoder with a sliding history window: top level.
//
// Tokens enter on a queue-style port: a token is taken at a clock edge with
// push high and full low. Results leave the same way: the oldest result sits
// on o_data/o_byte_count/o_last/o_error while empty is low and is taken on an
// edge with pop high. Registers are written over i_cfg_valid/o_cfg_ready
// (always ready) with index 0 = window_size, 1 = literal_bytes; write them
// only while no token is in flight.
// Intake checks the distance against the bytes held and forwards the token
// into a two-entry command queue, so tokens are taken while an earlier one is
// still being copied. The copy engine takes the token in a start step, reads
// each match byte from window memory into registered data and then writes it
// back, writes each literal byte directly and emits a result per 8 bytes: a
// token of L match and N literal bytes gives ceil((L+N)/8) results, an error
// token one empty last result. A stalled receiver holds one finished result in the
// output register; the engine then waits at its next emit and the command
// queue fills, raising full. Reset empties both queues, zeroes the history
// pointer and fill count and restores window_size 256, literal_bytes 1.
module lz77_window_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_distance,
    input  logic [7:0]                     i_match_length,
    input  logic [31:0]                    i_literal,
    output logic                           empty,
    input  logic                           pop,
    output logic [63:0]                    o_data,
    output logic [3:0]                     o_byte_count,
    output logic                           o_last,
    output logic                           o_error,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lzd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lzd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lzd_pkg::t_cmd    front_cmd;
    lzd_pkg::t_cmd    q_cmd;
    lzd_pkg::t_result res;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             in_accept;
    logic             res_valid;
    logic             res_pop;

    assign o_cfg_ready  = 1'b1;
    assign full         = q_full;
    assign in_accept    = push && !q_full;
    assign empty        = !res_valid;
    assign res_pop      = pop && res_valid;
    assign o_data       = res.data;
    assign o_byte_count = res.byte_count;
    assign o_last       = res.last;
    assign o_error      = res.error;

    lzd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (in_accept),
        .i_distance     (i_distance),
        .i_match_length (i_match_length),
        .i_literal      (i_literal),
        .o_cmd          (front_cmd)
    );

    lzd_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    lzd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_pop   (res_pop)
    );

`ifndef SYNTH
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_byte_count == 4'd0 && o_last))
        else $error("error beat must be empty and last");

    a_good_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_error) |-> (o_byte_count != 4'd0 && o_byte_count <= 4'd8))
        else $error("data beat byte count out of range");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");
`endif

endmodule
